@@ rtl/core/hte_pkg.sv @@
package hte_pkg;

	// item kinds
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_ENCODE = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	// table index of the end-of-stream code
	localparam int END_SYMBOL = 256;
	localparam int BYTE_BITS  = 8;
	// pending buffer holds at most one byte less one bit
	localparam int PEND_BITS  = 7;

	typedef struct packed {
		logic [1:0]  kind;
		logic [8:0]  symbol;
		logic [47:0] code_bits;
		logic [5:0]  code_len;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} result_t;

endpackage

@@ rtl/core/hte_ram.sv @@
module hte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/huffman_table_encoder.sv @@
// Huffman encoder with a loadable code table held in a synchronous RAM.
// After reset the block sweeps the table to empty codes, one entry per cycle,
// and stalls input items until the sweep is done.
// A load item is written to the RAM at its transfer; the block stays idle.
// An encode or end item goes through a table read, packing and the output
// of its bytes, at most (MAX_CODE_LEN + 14) / 8, then frees the input once
// its last byte sits in the output register, or after packing if none.
// Output bytes carry the earliest bit in the MSB; last_of_run marks the final
// byte of an item, and an end item pads its last partial byte with zeros.
module huffman_table_encoder #(
	parameter int MAX_CODE_LEN  = 48,
	parameter int TABLE_ENTRIES = 257
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  hte_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output hte_pkg::result_t result
);

	localparam int CW     = MAX_CODE_LEN;
	localparam int LW     = $clog2(MAX_CODE_LEN + 1);
	localparam int EW     = CW + LW;
	localparam int AW     = $clog2(TABLE_ENTRIES);
	localparam int ACC_W  = MAX_CODE_LEN + hte_pkg::PEND_BITS;
	localparam int TW     = $clog2(ACC_W + 1) + 1;
	localparam int NBW    = $clog2(ACC_W / hte_pkg::BYTE_BITS + 2);
	localparam int CNTW   = $clog2(hte_pkg::PEND_BITS + 1);
	localparam bit END_IN = hte_pkg::END_SYMBOL < TABLE_ENTRIES;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                   state_q;
	logic [AW-1:0]                clr_idx_q;
	logic [hte_pkg::PEND_BITS-1:0] pend_q;
	logic [CNTW-1:0]              pend_cnt_q;
	logic                         hit_s1;
	logic                         is_end_s1;
	logic                         is_end_q;
	logic [ACC_W-1:0]             aligned_q;
	logic [NBW-1:0]               nbytes_q;
	logic [CNTW-1:0]              rem_q;
	logic                         out_valid_q;
	hte_pkg::result_t             out_q;

	logic                         item_xfer;
	logic                         out_free;
	logic                         sym_in;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [EW-1:0]                wr_data;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [EW-1:0]                rd_data;
	logic [LW-1:0]                ld_len;
	logic [63:0]                  ld_mask;
	logic [63:0]                  ld_code;
	logic [CW-1:0]                rd_code;
	logic [LW-1:0]                rd_len;
	logic [ACC_W-1:0]             code_top;
	logic [ACC_W-1:0]             aligned;
	logic [TW-1:0]                total;
	logic [TW-1:0]                total_rnd;
	logic [NBW-1:0]               nbytes;
	logic [ACC_W-1:0]             aligned_sh;

	assign item_stall   = state_q != ST_IDLE;
	assign item_xfer    = item_valid && !item_stall;
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign sym_in       = 32'(item.symbol) < TABLE_ENTRIES;

	// load path: saturate the length and keep only the valid code bits
	always_comb begin
		if (32'(item.code_len) > MAX_CODE_LEN) begin
			ld_len = LW'(MAX_CODE_LEN);
		end else begin
			ld_len = LW'(item.code_len);
		end
		ld_mask = (ld_len == '0) ? 64'd0 : (~64'd0 >> (7'd64 - 7'(ld_len)));
		ld_code = 64'(item.code_bits) & ld_mask;
	end

	// table write: clearing sweep after reset, else load transfers
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_data = '0;
		end else begin
			wr_en   = item_xfer && item.kind == hte_pkg::KIND_LOAD && sym_in;
			wr_addr = AW'(item.symbol);
			wr_data = {ld_len, ld_code[CW-1:0]};
		end
	end

	// table read at the transfer of an encode or end item
	always_comb begin
		rd_en = item_xfer && (item.kind == hte_pkg::KIND_ENCODE ||
			item.kind == hte_pkg::KIND_END);
		if (item.kind == hte_pkg::KIND_END) begin
			rd_addr = AW'(hte_pkg::END_SYMBOL);
		end else begin
			rd_addr = AW'(item.symbol);
		end
	end

	hte_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// packing: left-align pending bits followed by the looked-up code
	always_comb begin
		rd_code   = hit_s1 ? rd_data[CW-1:0] : '0;
		rd_len    = hit_s1 ? rd_data[EW-1:CW] : '0;
		code_top  = ACC_W'(rd_code) << (TW'(ACC_W) - TW'(rd_len));
		aligned   = {pend_q, (ACC_W - hte_pkg::PEND_BITS)'(0)} | (code_top >> pend_cnt_q);
		total     = TW'(pend_cnt_q) + TW'(rd_len);
		total_rnd = is_end_s1 ? total + TW'(hte_pkg::BYTE_BITS - 1) : total;
		nbytes    = NBW'(total_rnd >> 3);
		aligned_sh = aligned_q << hte_pkg::BYTE_BITS;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			pend_q      <= '0;
			pend_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			hit_s1      <= 1'b0;
			is_end_s1   <= 1'b0;
			is_end_q    <= 1'b0;
			nbytes_q    <= '0;
			rem_q       <= '0;
		end else begin
			// output register: filled by the emit state, emptied by a transfer
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == AW'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (rd_en) begin
						is_end_s1 <= item.kind == hte_pkg::KIND_END;
						hit_s1    <= (item.kind == hte_pkg::KIND_END) ? END_IN : sym_in;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					nbytes_q <= nbytes;
					is_end_q <= is_end_s1;
					rem_q    <= total[CNTW-1:0];
					if (nbytes == '0) begin
						// nothing complete: keep the bits pending
						pend_q     <= aligned[ACC_W-1 -: hte_pkg::PEND_BITS];
						pend_cnt_q <= total[CNTW-1:0];
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						nbytes_q <= nbytes_q - NBW'(1);
						if (nbytes_q == NBW'(1)) begin
							if (is_end_q) begin
								pend_q     <= '0;
								pend_cnt_q <= '0;
							end else begin
								pend_q     <= aligned_sh[ACC_W-1 -: hte_pkg::PEND_BITS];
								pend_cnt_q <= rem_q;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers: aligned bit window and the output byte
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			aligned_q <= aligned;
		end else if (state_q == ST_EMIT && out_free) begin
			aligned_q         <= aligned_sh;
			out_q.out_byte    <= aligned_q[ACC_W-1 -: hte_pkg::BYTE_BITS];
			out_q.last_of_run <= nbytes_q == NBW'(1);
		end
	end

endmodule
